>>> design/dvc_pkg.sv
package dvc_pkg;

  // field widths
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned DATA_W = 40;

  // item modes
  localparam logic [MODE_W-1:0] MODE_RECV = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic capture;
    logic rd_item;
    logic rcv_update;
    logic load_own;
    logic load_thr;
    logic rd_scan;
    logic p1_chk;
    logic emit;
    logic p2_adv;
    logic emit_empty;
    logic save_sent;
    logic bump;
  } dvc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              last_entry;
    logic              qual;
    logic              found;
    logic              scan_last;
    logic              scan_final;
    logic              out_free;
  } dvc_status_t;

endpackage

>>> design/dvc_ctrl.sv
module dvc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dvc_pkg::dvc_status_t status,
  output dvc_pkg::dvc_cmd_t    cmd
);

  typedef enum logic [3:0] {
    CLEAR,
    IDLE,
    FETCH,
    RCV_UPD,
    TICK_LOAD,
    SEND_THR,
    P1_RD,
    P1_CHK,
    P2_RD,
    P2_CHK,
    EMPTY,
    SAVE,
    BUMP
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = status.scan_last ? IDLE : CLEAR;
      end
      IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = FETCH;
        end
      end
      FETCH: begin
        cmd.rd_item = 1'b1;
        case (status.mode)
          dvc_pkg::MODE_RECV: state_next = RCV_UPD;
          dvc_pkg::MODE_SEND: state_next = SEND_THR;
          dvc_pkg::MODE_TICK: state_next = TICK_LOAD;
          default:            state_next = IDLE;
        endcase
      end
      RCV_UPD: begin
        cmd.rcv_update = 1'b1;
        state_next     = status.last_entry ? BUMP : IDLE;
      end
      TICK_LOAD: begin
        cmd.load_own = 1'b1;
        state_next   = BUMP;
      end
      SEND_THR: begin
        cmd.load_thr = 1'b1;
        state_next   = P1_RD;
      end
      P1_RD: begin
        cmd.rd_scan = 1'b1;
        state_next  = P1_CHK;
      end
      P1_CHK: begin
        cmd.p1_chk = 1'b1;
        if (status.scan_last) begin
          state_next = (status.found || status.qual) ? P2_RD : EMPTY;
        end else begin
          state_next = P1_RD;
        end
      end
      P2_RD: begin
        cmd.rd_scan = 1'b1;
        state_next  = P2_CHK;
      end
      P2_CHK: begin
        // hold while a qualifying entry waits for the output register
        if (!(status.qual && !status.out_free)) begin
          cmd.emit = status.qual;
          if (status.scan_final) begin
            state_next = SAVE;
          end else begin
            cmd.p2_adv = 1'b1;
            state_next = P2_RD;
          end
        end
      end
      EMPTY: begin
        if (status.out_free) begin
          cmd.emit_empty = 1'b1;
          state_next     = SAVE;
        end
      end
      SAVE: begin
        cmd.save_sent = 1'b1;
        state_next    = BUMP;
      end
      BUMP: begin
        cmd.bump   = 1'b1;
        state_next = IDLE;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> design/dvc_datapath.sv
module dvc_datapath #(
  parameter int unsigned NODES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dvc_pkg::dvc_cmd_t                   cmd,
  output dvc_pkg::dvc_status_t                status,
  input  logic [dvc_pkg::IDX_W-1:0]           cfg_data,
  input  logic                                cfg_valid,
  input  logic [dvc_pkg::DATA_W-1:0]          in_data,
  input  logic [dvc_pkg::MODE_W-1:0]          in_user,
  input  logic                                in_last,
  output logic [dvc_pkg::DATA_W-1:0]          out_data,
  output logic                                out_user,
  output logic                                out_last,
  output logic                                out_valid,
  input  logic                                out_ready
);

  localparam int unsigned IW = $clog2(NODES);
  localparam int unsigned VW = dvc_pkg::VAL_W;
  localparam int unsigned XW = 9;
  localparam logic [XW-1:0] NODES_X = XW'(NODES);
  localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

  // captured item and configuration
  logic [dvc_pkg::MODE_W-1:0] item_mode;
  logic [dvc_pkg::IDX_W-1:0]  item_idx;
  logic [VW-1:0]              item_val;
  logic                       item_last;
  logic [dvc_pkg::IDX_W-1:0]  item_dst;
  logic [dvc_pkg::IDX_W-1:0]  own_node;

  // working registers
  logic [VW-1:0] own_clk;
  logic [VW-1:0] thr;
  logic [IW-1:0] scan;
  logic [IW-1:0] final_idx;
  logic          found;

  // memories, zeroed by the clearing pass after reset
  logic [VW-1:0] cv_mem [NODES];
  logic [VW-1:0] lu_mem [NODES];
  logic [VW-1:0] ls_mem [NODES];

  // registered read data
  logic [VW-1:0] cv_a_rd;
  logic [VW-1:0] cv_b_rd;
  logic [VW-1:0] lu_rd;
  logic [VW-1:0] ls_rd;

  // index range checks
  logic [XW-1:0] idx_x;
  logic [XW-1:0] own_x;
  logic [XW-1:0] dst_x;
  logic [XW-1:0] scan_x;
  logic          idx_ok;
  logic          own_ok;
  logic          dst_ok;
  logic [IW-1:0] idx_a;
  logic [IW-1:0] own_a;
  logic [IW-1:0] dst_a;

  assign idx_x  = {5'b0, item_idx};
  assign own_x  = {5'b0, own_node};
  assign dst_x  = {5'b0, item_dst};
  assign scan_x = XW'(scan);
  assign idx_ok = idx_x < NODES_X;
  assign own_ok = own_x < NODES_X;
  assign dst_ok = dst_x < NODES_X;
  assign idx_a  = idx_x[IW-1:0];
  assign own_a  = own_x[IW-1:0];
  assign dst_a  = dst_x[IW-1:0];

  // own clock reads as zero when own_node is out of range
  logic [VW-1:0] own_eff;
  assign own_eff = own_ok ? cv_b_rd : '0;

  // receive update decision and last-update stamp
  logic          upd;
  logic          hit_own;
  logic [VW-1:0] stamp;

  assign upd     = idx_ok && (cv_a_rd < item_val);
  assign hit_own = upd && own_ok && (item_idx == own_node);
  assign stamp   = hit_own ? item_val : own_eff;

  // own clock increment
  logic bump_ok;
  assign bump_ok = own_ok && (own_clk != '1);

  // clock vector ports
  logic          cv_we;
  logic [IW-1:0] cv_wa;
  logic [VW-1:0] cv_wd;
  logic [IW-1:0] cv_ra;
  logic          cv_re;

  assign cv_we = cmd.clear || (cmd.rcv_update && upd) || (cmd.bump && bump_ok);
  assign cv_wa = cmd.clear ? scan : (cmd.rcv_update ? idx_a : own_a);
  assign cv_wd = cmd.clear ? '0 : (cmd.rcv_update ? item_val : (own_clk + VW'(1)));
  assign cv_ra = cmd.rd_item ? idx_a : scan;
  assign cv_re = cmd.rd_item || cmd.rd_scan;

  // last-update and last-sent write ports
  logic          lu_we;
  logic [IW-1:0] lu_wa;
  logic [VW-1:0] lu_wd;
  logic          ls_we;
  logic [IW-1:0] ls_wa;
  logic [VW-1:0] ls_wd;

  assign lu_we = cmd.clear || (cmd.rcv_update && upd);
  assign lu_wa = cmd.clear ? scan : idx_a;
  assign lu_wd = cmd.clear ? '0 : stamp;
  assign ls_we = cmd.clear || (cmd.save_sent && dst_ok);
  assign ls_wa = cmd.clear ? scan : dst_a;
  assign ls_wd = cmd.clear ? '0 : own_clk;

  // scan qualifiers
  logic qual;
  assign qual = lu_rd >= thr;

  // status to controller
  assign status.mode       = item_mode;
  assign status.last_entry = item_last;
  assign status.qual       = qual;
  assign status.found      = found;
  assign status.scan_last  = (scan == LAST_IDX);
  assign status.scan_final = (scan == final_idx);
  assign status.out_free   = !out_valid || out_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      own_node <= '0;
    end else if (cfg_valid) begin
      own_node <= cfg_data;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode <= in_user;
      item_idx  <= in_data[3:0];
      item_val  <= in_data[35:4];
      item_dst  <= in_data[39:36];
      item_last <= in_last;
    end
  end

  // clock vector memory
  always_ff @(posedge clk) begin
    if (cv_we) begin
      cv_mem[cv_wa] <= cv_wd;
    end
    if (cv_re) begin
      cv_a_rd <= cv_mem[cv_ra];
    end
    if (cmd.rd_item) begin
      cv_b_rd <= cv_mem[own_a];
    end
  end

  // last-update memory
  always_ff @(posedge clk) begin
    if (lu_we) begin
      lu_mem[lu_wa] <= lu_wd;
    end
    if (cmd.rd_scan) begin
      lu_rd <= lu_mem[scan];
    end
  end

  // last-sent memory
  always_ff @(posedge clk) begin
    if (ls_we) begin
      ls_mem[ls_wa] <= ls_wd;
    end
    if (cmd.rd_item) begin
      ls_rd <= ls_mem[dst_a];
    end
  end

  // own clock copy and send threshold
  always_ff @(posedge clk) begin
    if (cmd.rcv_update) begin
      own_clk <= stamp;
    end else if (cmd.load_own || cmd.load_thr) begin
      own_clk <= own_eff;
    end
    if (cmd.load_thr) begin
      thr <= dst_ok ? ls_rd : '0;
    end
  end

  // scan counter, clearing address and last qualifying entry
  always_ff @(posedge clk) begin
    if (rst) begin
      scan      <= '0;
      found     <= 1'b0;
      final_idx <= '0;
    end else if (cmd.clear) begin
      scan <= (scan == LAST_IDX) ? '0 : (scan + IW'(1));
    end else if (cmd.load_thr) begin
      scan  <= '0;
      found <= 1'b0;
    end else if (cmd.p1_chk) begin
      if (qual) begin
        final_idx <= scan;
        found     <= 1'b1;
      end
      scan <= (scan == LAST_IDX) ? '0 : (scan + IW'(1));
    end else if (cmd.p2_adv) begin
      scan <= scan + IW'(1);
    end
  end

  // output register
  logic [dvc_pkg::IDX_W-1:0] out_index;
  logic [VW-1:0]             out_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_index <= scan_x[3:0];
      out_value <= cv_a_rd;
      out_user  <= 1'b1;
      out_last  <= (scan == final_idx);
    end else if (cmd.emit_empty) begin
      out_index <= '0;
      out_value <= '0;
      out_user  <= 1'b0;
      out_last  <= 1'b1;
    end
  end

  assign out_data = {4'b0, out_value, out_index};

endmodule

>>> design/differential_vector_clock_unit.sv
// Differential vector clock for one node: keeps the vector clock, the
// last-update vector and the last-sent-per-neighbour vector, each NODES
// entries of 32 bits held in memories that a clearing pass fills with
// zeros after reset; the input is held off during that pass.
// Input tuser selects the mode: receive a (index, value) pair, send to a
// neighbour, or local tick. A received pair updates its entry if the value
// is larger, and when tlast ends the message it also bumps the own clock;
// a tick loads and bumps the own clock. A send scans the memories twice,
// once over all entries to find the final qualifying entry k and once up
// to k to emit, reading and then checking each entry in each pass, and it
// waits while the output is stalled. Results leave through a registered
// output stage; tlast marks the final result of a send and tuser is 0 on
// the empty message marker. The own clock saturates at all ones. The user
// must write own_node through the cfg port only while idle; the block
// does not enforce this.
module differential_vector_clock_unit #(
  parameter int unsigned NODES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: own_node
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dvc_pkg::IDX_W-1:0]     cfg_data,
  // input beat
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // entry_index [3:0], entry_value [35:4], destination [39:36]
  input  logic [dvc_pkg::DATA_W-1:0]    s_axis_tdata,
  // mode [1:0]
  input  logic [dvc_pkg::MODE_W-1:0]    s_axis_tuser,
  input  logic                          s_axis_tlast,
  // result beat
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_index [3:0], out_value [35:4], zero [39:36]
  output logic [dvc_pkg::DATA_W-1:0]    m_axis_tdata,
  // has_entry [0]
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);

  dvc_pkg::dvc_cmd_t    cmd;
  dvc_pkg::dvc_status_t status;

  assign cfg_ready = 1'b1;

  // sequencer
  dvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // storage, compare and output stage
  dvc_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .in_last   (s_axis_tlast),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready)
  );

endmodule
